>>> rtl/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

>>> rtl/kfpi_pkg.sv
// shared types and constants of the keyframe pose interpolator
// no dependencies
package kfpi_pkg;
  localparam int MOTIONS_DEF = 8;
  localparam int KEYS_DEF = 16;
  localparam int PARTS_DEF = 16;
  localparam int VW = 20;
  localparam logic [2:0] MODE_KEY = 3'd0;
  localparam logic [2:0] MODE_DUR = 3'd1;
  localparam logic [2:0] MODE_HDR = 3'd2;
  localparam logic [2:0] MODE_BASE = 3'd3;
  localparam logic [2:0] MODE_START = 3'd4;
  localparam logic [2:0] MODE_TICK = 3'd5;
endpackage

>>> rtl/kfpi_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module kfpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/kfpi_div.sv
// restoring divider, one quotient bit a cycle, signed numerator, truncates to zero
// depends on nothing
module kfpi_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [28:0] num,
  input  logic [7:0]         den,
  output logic               busy,
  output logic signed [28:0] quo
);
  logic [27:0] n;
  logic [27:0] q;
  logic [8:0]  r;
  logic [4:0]  cnt;
  logic        neg;
  logic [8:0]  trial;
  logic [8:0]  sh;
  assign sh    = {r[7:0], n[27]};
  assign trial = sh - {1'b0, den};
  assign quo   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd28;
      neg  <= num[28];
      n    <= num[28] ? 28'(-num) : num[27:0];
      r    <= '0;
      q    <= '0;
    end else if (busy) begin
      n <= {n[26:0], 1'b0};
      if (!trial[8]) begin
        r <= trial;
        q <= {q[26:0], 1'b1};
      end else begin
        r <= sh;
        q <= {q[26:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end
endmodule

>>> rtl/keyframe_pose_interpolator.sv
// top level of the keyframe pose interpolator
// depends on kfpi_pkg, kfpi_ram, kfpi_div and assert_macros.svh
//
// usage: s_axis items carry their kind in tuser (key pose, key duration,
// motion header, base pose, start, tick) and their fields in tdata. loads
// and starts (header read) yield nothing. a tick yields one m_axis item
// per part in use (parts_in_use clamped to 1..PARTS, at most 16), parts in
// order, tlast on the final one. each part runs the memory reads, the six
// divisions on the one shared bit-serial divider and the load of the output
// register, in that order. the block takes one item at a time;
// s_axis_tready is low while a start or tick works or a result waits in
// the output register. a stalled receiver holds the result register, and
// the walk waits at the next result. reset returns the player to motion 0,
// one key, no loop, key 0, counter 0, not finished, parts_in_use 1; the
// stores are undefined until loaded. cfg is to be written only while the
// block is idle; the block itself does not enforce it.
`include "assert_macros.svh"
module keyframe_pose_interpolator #(
  parameter int MOTIONS = kfpi_pkg::MOTIONS_DEF,
  parameter int KEYS    = kfpi_pkg::KEYS_DEF,
  parameter int PARTS   = kfpi_pkg::PARTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // motion_index, key_index, part_index, pos_x..rot_z, amount, loop_flag, pad
  input  logic [143:0] s_axis_tdata,
  // mode
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tready,
  output logic         m_axis_tvalid,
  // part_out, pos_x_out..rot_z_out, finished, pad
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  localparam int MW = (MOTIONS > 1) ? $clog2(MOTIONS) : 1;
  localparam int KW = $clog2(KEYS);
  localparam int CW = KW + 1;
  localparam int PW = (PARTS > 1) ? $clog2(PARTS) : 1;
  localparam int VW = kfpi_pkg::VW;
  localparam int KAW = MW + KW + PW;
  localparam int DAW = MW + KW;
  localparam int NLIM = (PARTS < 16) ? PARTS : 16;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HDR  = 4'd1;
  localparam logic [3:0] S_DUR  = 4'd2;
  localparam logic [3:0] S_RDA  = 4'd3;
  localparam logic [3:0] S_RDB  = 4'd4;
  localparam logic [3:0] S_LAT  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_DWT  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // input fields
  logic [2:0] mode;
  logic [2:0] motion_index;
  logic [3:0] key_index, part_index;
  logic [7:0] amount;
  logic       loop_flag;
  logic [6*VW-1:0] vin;
  assign mode         = s_axis_tuser;
  assign motion_index = s_axis_tdata[2:0];
  assign key_index    = s_axis_tdata[6:3];
  assign part_index   = s_axis_tdata[10:7];
  assign vin          = s_axis_tdata[130:11];
  assign amount       = s_axis_tdata[138:131];
  assign loop_flag    = s_axis_tdata[139];

  logic [3:0] state;
  logic [4:0] parts_in_use;
  logic [MW-1:0] active_motion;
  logic [CW-1:0] active_count;
  logic active_loop;
  logic [KW-1:0] current_key;
  logic [7:0] frame_counter;
  logic done_flag;
  logic was_done;
  logic [KW-1:0] nowk, nextk;
  logic [7:0] dur;
  logic [PW-1:0] part;
  logic [4:0] nparts;
  logic [2:0] comp;
  logic signed [VW-1:0] va [6];
  logic signed [VW-1:0] vb [6];
  logic signed [VW-1:0] vbase [6];
  logic signed [VW-1:0] res [6];

  wire acc = s_axis_tvalid && s_axis_tready;
  wire in_m = 32'(motion_index) < MOTIONS;
  wire in_k = 32'(key_index) < KEYS;
  wire in_p = 32'(part_index) < PARTS;

  // clamp of a key count to 1..KEYS
  function automatic logic [CW-1:0] clampc(input logic [7:0] c);
    if (c == 8'd0) return CW'(1);
    if (32'(c) > KEYS) return CW'(KEYS);
    return CW'(c);
  endfunction

  // memories
  logic key_we;
  logic [KAW-1:0] key_waddr, key_raddr;
  logic [6*VW-1:0] key_rdata;
  logic dur_we;
  logic [DAW-1:0] dur_waddr, dur_raddr;
  logic [7:0] dur_rdata;
  logic hdr_we;
  logic [CW:0] hdr_rdata;
  logic base_we;
  logic [6*VW-1:0] base_rdata;

  assign key_we   = acc && mode == kfpi_pkg::MODE_KEY && in_m && in_k && in_p;
  assign key_waddr = {MW'(motion_index), KW'(key_index), PW'(part_index)};
  assign dur_we   = acc && mode == kfpi_pkg::MODE_DUR && in_m && in_k;
  assign dur_waddr = {MW'(motion_index), KW'(key_index)};
  assign hdr_we   = acc && mode == kfpi_pkg::MODE_HDR && in_m;
  assign base_we  = acc && mode == kfpi_pkg::MODE_BASE && in_p;

  kfpi_ram #(.WIDTH(6*VW), .DEPTH(1 << KAW)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(vin),
    .raddr(key_raddr), .rdata(key_rdata));
  kfpi_ram #(.WIDTH(8), .DEPTH(1 << DAW)) u_dur (
    .clk(clk), .we(dur_we), .waddr(dur_waddr), .wdata(amount),
    .raddr(dur_raddr), .rdata(dur_rdata));
  // header entry: loop flag above the clamped key count
  kfpi_ram #(.WIDTH(CW+1), .DEPTH(1 << MW)) u_hdr (
    .clk(clk), .we(hdr_we), .waddr(MW'(motion_index)),
    .wdata({loop_flag, clampc(amount)}),
    .raddr(MW'(motion_index)), .rdata(hdr_rdata));
  kfpi_ram #(.WIDTH(6*VW), .DEPTH(1 << PW)) u_base (
    .clk(clk), .we(base_we), .waddr(PW'(part_index)), .wdata(vin),
    .raddr(part), .rdata(base_rdata));

  assign dur_raddr = {active_motion, nowk};
  assign key_raddr = {active_motion, (state == S_RDB) ? nextk : nowk, part};

  // divider
  logic div_start, div_busy;
  logic signed [28:0] div_num, div_quo;
  logic signed [VW:0] diff;
  assign diff = {vb[comp][VW-1], vb[comp]} - {va[comp][VW-1], va[comp]};
  assign div_num = 29'(diff * $signed({1'b0, frame_counter}));
  kfpi_div u_div (.clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(dur), .busy(div_busy), .quo(div_quo));
  assign div_start = (state == S_DIV);

  // saturated sum of base, now and quotient
  logic signed [30:0] sum;
  logic signed [VW-1:0] sat;
  assign sum = 31'(vbase[comp]) + 31'(va[comp]) + (was_done ? 31'sd0 : 31'(div_quo));
  always_comb begin
    if (sum > 31'sd524287) sat = 20'sh7FFFF;
    else if (sum < -31'sd524288) sat = 20'sh80000;
    else sat = sum[VW-1:0];
  end

  // next player state after the tick
  logic [7:0] fc_inc;
  logic step;
  logic fin_after;
  logic [KW-1:0] key_adv;
  assign fc_inc = frame_counter + 8'd1;
  // end of the key's duration, counter at or past it
  assign step = !was_done && fc_inc >= dur;
  // finished flag as it stands after the advance, sent with every part
  assign fin_after = was_done ||
    (step && !active_loop &&
     (active_count == CW'(1) || CW'(nowk) + CW'(1) >= active_count - CW'(1)));
  always_comb begin
    if (!step || active_count == CW'(1)) key_adv = nowk;
    else if (active_loop)
      key_adv = (CW'(nowk) + CW'(1) >= active_count) ? '0 : nowk + KW'(1);
    else if (CW'(nowk) + CW'(1) >= active_count - CW'(1))
      key_adv = KW'(active_count - CW'(1));
    else key_adv = nowk + KW'(1);
  end

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      parts_in_use <= 5'd1;
      active_motion <= '0;
      active_count <= CW'(1);
      active_loop <= 1'b0;
      current_key <= '0;
      frame_counter <= '0;
      done_flag <= 1'b0;
      m_axis_tvalid <= 1'b0;
      part <= '0;
      comp <= '0;
    end else begin
      if (cfg_valid) parts_in_use <= cfg_data;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc && mode == kfpi_pkg::MODE_START && in_m) begin
            active_motion <= MW'(motion_index);
            state <= S_HDR;
          end else if (acc && mode == kfpi_pkg::MODE_TICK) begin
            was_done <= done_flag;
            if (done_flag) begin
              nowk <= KW'(active_count - CW'(1));
              nextk <= KW'(active_count - CW'(1));
            end else begin
              nowk <= (CW'(current_key) >= active_count) ? '0 : current_key;
              // a key past the count restarts at key 0
              if (active_count == CW'(1)) nextk <= '0;
              else if (CW'(current_key) >= active_count) nextk <= KW'(1);
              else if (CW'(current_key) + CW'(1) >= active_count) nextk <= '0;
              else nextk <= current_key + KW'(1);
            end
            if (parts_in_use == 5'd0) nparts <= 5'd1;
            else if (32'(parts_in_use) > NLIM) nparts <= 5'(NLIM);
            else nparts <= parts_in_use;
            part <= '0;
            state <= S_DUR;
          end
        end
        S_HDR: begin
          active_count <= hdr_rdata[CW-1:0];
          active_loop <= hdr_rdata[CW];
          current_key <= '0;
          frame_counter <= '0;
          done_flag <= 1'b0;
          state <= S_IDLE;
        end
        S_DUR: begin
          state <= S_RDA;
        end
        S_RDA: begin
          dur <= (dur_rdata == 8'd0) ? 8'd1 : dur_rdata;
          state <= S_RDB;
        end
        S_RDB: begin
          for (int i = 0; i < 6; i++) begin
            va[i] <= key_rdata[i*VW +: VW];
            vbase[i] <= base_rdata[i*VW +: VW];
          end
          state <= S_LAT;
        end
        S_LAT: begin
          for (int i = 0; i < 6; i++) vb[i] <= key_rdata[i*VW +: VW];
          comp <= '0;
          state <= S_DIV;
        end
        S_DIV: state <= S_DWT;
        S_DWT: begin
          if (!div_busy) begin
            res[comp] <= sat;
            if (comp == 3'd5) state <= S_OUT;
            else begin
              comp <= comp + 3'd1;
              state <= S_DIV;
            end
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast <= (5'(part) + 5'd1 == nparts);
            m_axis_tdata <= {3'b000, fin_after, res[5], res[4], res[3], res[2],
                             res[1], res[0], 4'(part)};
            if (5'(part) + 5'd1 == nparts) begin
              // advance the player after the final part
              if (!was_done) begin
                frame_counter <= step ? 8'd0 : fc_inc;
                current_key <= key_adv;
              end
              done_flag <= fin_after;
              state <= S_IDLE;
            end else begin
              part <= part + PW'(1);
              state <= S_DUR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_busy_noready, clk, rst, state != S_IDLE, !s_axis_tready)
  `CHK_IMPL(a_part_range, clk, rst, m_axis_tvalid, 5'(m_axis_tdata[3:0]) < nparts)
  `CHK_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of keyframe_pose_interpolator: drives load, start and tick items,
// predicts every part pose of each tick and checks the result stream with random stalls
// depends on kfpi_pkg and the rtl of keyframe_pose_interpolator
module testbench;

  typedef struct {
    logic [2:0] mode;
    logic [2:0] motion;
    logic [3:0] key;
    logic [3:0] part;
    logic signed [19:0] v [6];
    logic [7:0] amount;
    logic       loop_bit;
  } anim_item_t;

  typedef struct {
    logic [3:0] part;
    logic signed [19:0] v [6];
    logic       last;
    logic       fin;
  } part_pose_t;

  // predictor of the player plus the queue of poses still owed by the block
  class pose_predictor;
    logic signed [19:0] key_pose [8][16][16][6];
    bit                 key_set [8][16][16];
    logic [7:0]         dur [8][16];
    bit                 dur_set [8][16];
    int                 hdr_cnt [8];
    bit                 hdr_loop [8];
    bit                 hdr_set [8];
    logic signed [19:0] base [16][6];
    bit                 base_set [16];
    int                 parts_reg = 1;
    int                 act_m = 0, act_cnt = 1, cur_key = 0, frame_cnt = 0;
    bit                 act_loop = 0, done = 0;
    int                 errors = 0;
    part_pose_t         owed_poses [$];

    function int clamp_keys(int c);
      return (c < 1) ? 1 : (c > 16) ? 16 : c;
    endfunction

    function int parts_now();
      return (parts_reg < 1) ? 1 : (parts_reg > 16) ? 16 : parts_reg;
    endfunction

    function void note_item(anim_item_t it);
      part_pose_t tick_poses [$];
      part_pose_t r;
      int nowk, nextk, d, n;
      longint a, b, q, s;
      bit was_done;
      case (it.mode)
        kfpi_pkg::MODE_KEY: begin
          key_pose[it.motion][it.key][it.part] = it.v;
          key_set[it.motion][it.key][it.part] = 1;
        end
        kfpi_pkg::MODE_DUR: begin
          dur[it.motion][it.key] = it.amount;
          dur_set[it.motion][it.key] = 1;
        end
        kfpi_pkg::MODE_HDR: begin
          hdr_cnt[it.motion] = clamp_keys(int'(it.amount));
          hdr_loop[it.motion] = it.loop_bit;
          hdr_set[it.motion] = 1;
        end
        kfpi_pkg::MODE_BASE: begin
          base[it.part] = it.v;
          base_set[it.part] = 1;
        end
        kfpi_pkg::MODE_START: begin
          act_m = int'(it.motion);
          act_cnt = clamp_keys(hdr_cnt[it.motion]);
          act_loop = hdr_loop[it.motion];
          cur_key = 0;
          frame_cnt = 0;
          done = 0;
        end
        kfpi_pkg::MODE_TICK: begin
          if (cur_key >= act_cnt) cur_key = 0;
          was_done = done;
          // finished motions hold the last key
          if (was_done) begin
            nowk = act_cnt - 1;
            nextk = nowk;
          end else begin
            nowk = cur_key;
            nextk = (act_cnt == 1) ? 0 : (cur_key + 1) % act_cnt;
          end
          d = (dur[act_m][nowk] == 8'd0) ? 1 : int'(dur[act_m][nowk]);
          n = parts_now();
          for (int p = 0; p < n; p++) begin
            r.part = 4'(p);
            for (int i = 0; i < 6; i++) begin
              a = longint'(key_pose[act_m][nowk][p][i]);
              b = longint'(key_pose[act_m][nextk][p][i]);
              q = ((b - a) * frame_cnt) / d;
              s = longint'(base[p][i]) + a + (was_done ? 0 : q);
              if (s > 524287) s = 524287;
              if (s < -524288) s = -524288;
              r.v[i] = s[19:0];
            end
            r.last = (p + 1 == n);
            tick_poses.push_back(r);
          end
          if (!was_done) begin
            frame_cnt = (frame_cnt + 1) & 8'hFF;
            // counter at or past the duration steps the key
            if (frame_cnt >= d) begin
              frame_cnt = 0;
              if (act_cnt == 1) begin
                if (!act_loop) done = 1;
              end else begin
                cur_key++;
                if (act_loop) begin
                  if (cur_key >= act_cnt) cur_key = 0;
                end else if (cur_key >= act_cnt - 1) begin
                  cur_key = act_cnt - 1;
                  done = 1;
                end
              end
            end
          end
          foreach (tick_poses[j]) begin
            tick_poses[j].fin = done;
            owed_poses.push_back(tick_poses[j]);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pose(part_pose_t got);
      part_pose_t exp_pose;
      if (owed_poses.size() == 0) begin
        $display("%0t: unexpected result, part %0d", $time, got.part);
        errors++;
        return;
      end
      exp_pose = owed_poses.pop_front();
      if (got.part !== exp_pose.part) begin
        $display("%0t: part expected %0d actual %0d", $time, exp_pose.part, got.part);
        errors++;
      end
      for (int i = 0; i < 6; i++)
        if (got.v[i] !== exp_pose.v[i]) begin
          $display("%0t: part %0d value %0d expected %0d actual %0d", $time,
                   exp_pose.part, i, exp_pose.v[i], got.v[i]);
          errors++;
        end
      if (got.last !== exp_pose.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp_pose.last, got.last);
        errors++;
      end
      if (got.fin !== exp_pose.fin) begin
        $display("%0t: finished expected %0b actual %0b", $time, exp_pose.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [4:0]   cfg_data = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tready = 0;
  logic         m_tvalid;
  logic [127:0] m_tdata;
  logic         m_tlast;

  pose_predictor pred = new();
  bit quiet = 0;
  int sent = 0;
  int stall = 0;

  keyframe_pose_interpolator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .s_axis_tuser(s_tuser),
    .m_axis_tready(m_tready), .m_axis_tvalid(m_tvalid), .m_axis_tdata(m_tdata),
    .m_axis_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  // coordinates lean on the saturation limits now and then
  function logic signed [19:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return 20'(int'($urandom_range(0, 2047)) - 1024);
      default: return 20'($urandom());
    endcase
  endfunction

  function anim_item_t make_item(logic [2:0] mode);
    anim_item_t it;
    it.mode = mode;
    it.motion = 3'($urandom());
    it.key = 4'($urandom());
    it.part = 4'($urandom());
    foreach (it.v[i]) it.v[i] = pick_coord();
    it.amount = 8'($urandom());
    it.loop_bit = 1'($urandom());
    return it;
  endfunction

  task automatic send(anim_item_t it);
    logic [143:0] d;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    d = '0;
    d[2:0] = it.motion;
    d[6:3] = it.key;
    d[10:7] = it.part;
    for (int i = 0; i < 6; i++) d[11 + 20 * i +: 20] = it.v[i];
    d[138:131] = it.amount;
    d[139] = it.loop_bit;
    s_tdata <= d;
    s_tuser <= it.mode;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred.note_item(it);
    sent++;
  endtask

  task automatic load_key(int m, int k, int p);
    anim_item_t it = make_item(kfpi_pkg::MODE_KEY);
    it.motion = 3'(m); it.key = 4'(k); it.part = 4'(p);
    send(it);
  endtask

  // short durations keep motions moving, a few long ones stretch the counter
  task automatic load_dur(int m, int k);
    anim_item_t it = make_item(kfpi_pkg::MODE_DUR);
    it.motion = 3'(m); it.key = 4'(k);
    if ($urandom_range(0, 9) != 0) it.amount = 8'($urandom_range(0, 4));
    send(it);
  endtask

  // now and then a key count past the table size
  task automatic load_header(int m);
    anim_item_t it = make_item(kfpi_pkg::MODE_HDR);
    it.motion = 3'(m);
    if ($urandom_range(0, 19) != 0) it.amount = 8'($urandom_range(0, 4));
    send(it);
  endtask

  // a tick only reads entries that were written before
  task automatic tick();
    int m, n;
    m = pred.act_m;
    n = pred.parts_now();
    for (int k = 0; k < pred.act_cnt; k++) begin
      if (!pred.dur_set[m][k]) load_dur(m, k);
      for (int p = 0; p < n; p++)
        if (!pred.key_set[m][k][p]) load_key(m, k, p);
    end
    for (int p = 0; p < n; p++)
      if (!pred.base_set[p]) send(make_item(kfpi_pkg::MODE_BASE) );
    for (int p = 0; p < n; p++)
      while (!pred.base_set[p]) begin
        anim_item_t it = make_item(kfpi_pkg::MODE_BASE);
        it.part = 4'(p);
        send(it);
      end
    send(make_item(kfpi_pkg::MODE_TICK));
  endtask

  task automatic start(int m);
    anim_item_t it = make_item(kfpi_pkg::MODE_START);
    if (!pred.hdr_set[m]) load_header(m);
    it.motion = 3'(m);
    send(it);
  endtask

  task automatic write_parts(logic [4:0] val);
    s_tvalid <= 1'b0;
    while (pred.owed_poses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pred.parts_reg = int'(val);
  endtask

  task automatic random_action();
    anim_item_t it;
    int pick = $urandom_range(0, 99);
    if (pick < 40) begin
      repeat ($urandom_range(1, 6)) tick();
    end else if (pick < 50) begin
      start($urandom_range(0, 7));
    end else if (pick < 62) begin
      load_header($urandom_range(0, 7));
    end else if (pick < 74) begin
      // mostly the playing motion, so durations shrink under the counter
      load_dur($urandom_range(0, 1) ? pred.act_m : $urandom_range(0, 7),
               $urandom_range(0, 15));
    end else if (pick < 88) begin
      it = make_item(kfpi_pkg::MODE_KEY);
      if ($urandom_range(0, 1)) it.motion = 3'(pred.act_m);
      send(it);
    end else if (pick < 96) begin
      send(make_item(kfpi_pkg::MODE_BASE));
    end else begin
      send(make_item(3'($urandom_range(6, 7))));
    end
  endtask

  // result side: check each accepted item, stall in bursts
  always @(posedge clk) begin
    part_pose_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.part = m_tdata[3:0];
        for (int i = 0; i < 6; i++) got.v[i] = m_tdata[4 + 20 * i +: 20];
        got.fin = m_tdata[124];
        got.last = m_tlast;
        pred.check_pose(got);
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    anim_item_t it;
    logic [4:0] phase_parts [7] = '{5'd3, 5'd0, 5'd16, 5'd5, 5'd31, 5'd2, 5'd1};
    int budget;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_parts(5'd1);

    // ignored modes
    send(make_item(3'd6));
    send(make_item(3'd7));
    // reset motion with extreme poses: saturation both ways, zero duration
    it = make_item(kfpi_pkg::MODE_BASE); it.part = 4'd0;
    foreach (it.v[i]) it.v[i] = 20'h7FFFF; send(it);
    it.mode = kfpi_pkg::MODE_KEY; it.motion = 3'd0; it.key = 4'd0; send(it);
    it = make_item(kfpi_pkg::MODE_DUR); it.motion = 3'd0; it.key = 4'd0;
    it.amount = 8'd0; send(it);
    tick(); tick();
    it = make_item(kfpi_pkg::MODE_BASE); it.part = 4'd0;
    foreach (it.v[i]) it.v[i] = 20'h80000; send(it);
    it.mode = kfpi_pkg::MODE_KEY; it.motion = 3'd0; it.key = 4'd0; send(it);
    tick();
    // one-key looping motion from a zero key count
    it = make_item(kfpi_pkg::MODE_HDR); it.motion = 3'd1; it.amount = 8'd0;
    it.loop_bit = 1'b1; send(it);
    start(1); tick(); tick(); tick();
    // three keys, stopping, full swing between the extremes
    it = make_item(kfpi_pkg::MODE_HDR); it.motion = 3'd2; it.amount = 8'd3;
    it.loop_bit = 1'b0; send(it);
    it = make_item(kfpi_pkg::MODE_DUR); it.motion = 3'd2; it.key = 4'd0;
    it.amount = 8'd2; send(it);
    it.key = 4'd1; it.amount = 8'd0; send(it);
    it.key = 4'd2; it.amount = 8'd5; send(it);
    it = make_item(kfpi_pkg::MODE_KEY); it.motion = 3'd2; it.key = 4'd0; it.part = 4'd0;
    foreach (it.v[i]) it.v[i] = 20'h80000; send(it);
    it.key = 4'd1; foreach (it.v[i]) it.v[i] = 20'h7FFFF; send(it);
    start(2);
    repeat (6) tick();
    // key count past the table size clamps
    it = make_item(kfpi_pkg::MODE_HDR); it.motion = 3'd3; it.amount = 8'd255;
    it.loop_bit = 1'b1; send(it);

    foreach (phase_parts[ph]) begin
      write_parts(phase_parts[ph]);
      if (ph == 6) quiet = 1;
      budget = sent + ((phase_parts[ph] >= 5'd16) ? 25 : 75);
      while (sent < budget) random_action();
    end

    s_tvalid <= 1'b0;
    while (pred.owed_poses.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (pred.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/kfpi_pkg.sv
rtl/kfpi_ram.sv
rtl/kfpi_div.sv
rtl/keyframe_pose_interpolator.sv
tb/testbench.sv
